[design/aabb_unit_block_contact_unit_defines.svh]
// Assertion macros for the block contact unit.
// Each macro takes a label, the clock, the reset and the two sides of an implication.
`ifndef AABB_UNIT_BLOCK_CONTACT_UNIT_DEFINES_SVH
`define AABB_UNIT_BLOCK_CONTACT_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define AABBC_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("aabbc assertion failed");

// Next-cycle implication
`define AABBC_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("aabbc assertion failed");

`else

`define AABBC_ASSERT_IMPLY(label, clk, rst, lhs, rhs)
`define AABBC_ASSERT_NEXT(label, clk, rst, lhs, rhs)

`endif

`endif

[design/aabbc_pkg.sv]
package aabbc_pkg;

   localparam int MAX_FRAC_BITS = 16;
   localparam int DEF_FRAC_BITS = 8;

   localparam int CUBE_W   = 16;
   localparam int POS_W    = 24;
   localparam int EXT_W    = 16;
   localparam int DEPTH_W  = 16;
   localparam int CSR_IDX_W = 2;

   // Wide enough for a cube corner scaled by the largest fraction width,
   // plus its far face, plus one difference.
   localparam int CALC_W = CUBE_W + MAX_FRAC_BITS + 4;

   typedef logic signed [CALC_W-1:0] calc_type;
   typedef logic signed [POS_W-1:0]  pos_type;

   localparam calc_type CONTACT_MAX = calc_type'(8388607);
   localparam calc_type CONTACT_MIN = -calc_type'(8388608);
   localparam calc_type DEPTH_MAX   = calc_type'(65535);

   localparam logic [EXT_W-1:0] HALF_SPAN_RESET   = 16'd77;
   localparam logic [EXT_W-1:0] BODY_HEIGHT_RESET = 16'd461;

   localparam logic [CSR_IDX_W-1:0] CSR_HALF_SPAN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BODY_HEIGHT = 2'd1;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef struct packed {
      logic     hit;
      logic     neg;
      calc_type overlap;
      calc_type correction;
      pos_type  contact;
   } axis_result_type;

   typedef struct packed {
      axis_type             axis;
      logic                 neg;
      pos_type              contact_x;
      pos_type              contact_y;
      pos_type              contact_z;
      logic [DEPTH_W-1:0]   depth;
   } contact_type;

endpackage

[design/aabbc_axis.sv]
module aabbc_axis #(
   parameter int FRAC_BITS = aabbc_pkg::DEF_FRAC_BITS
) (
   input  logic signed [aabbc_pkg::CUBE_W-1:0] cube_pos,
   input  logic signed [aabbc_pkg::POS_W-1:0]  body_pos,
   input  logic [aabbc_pkg::EXT_W-1:0]         ext_below,
   input  logic [aabbc_pkg::EXT_W-1:0]         ext_above,
   output aabbc_pkg::axis_result_type          result
);

   aabbc_pkg::calc_type one_unit;
   aabbc_pkg::calc_type cube_min;
   aabbc_pkg::calc_type cube_max;
   aabbc_pkg::calc_type body_ctr;
   aabbc_pkg::calc_type body_min;
   aabbc_pkg::calc_type body_max;
   aabbc_pkg::calc_type near_max;
   aabbc_pkg::calc_type far_min;
   aabbc_pkg::calc_type pos_push;
   aabbc_pkg::calc_type neg_push;
   aabbc_pkg::calc_type clamped;

   assign one_unit = aabbc_pkg::calc_type'(1) <<< FRAC_BITS;
   assign cube_min = aabbc_pkg::calc_type'(cube_pos) <<< FRAC_BITS;
   assign cube_max = cube_min + one_unit;
   assign body_ctr = aabbc_pkg::calc_type'(body_pos);
   assign body_min = body_ctr - aabbc_pkg::calc_type'(ext_below);
   assign body_max = body_ctr + aabbc_pkg::calc_type'(ext_above);

   assign near_max = (body_max < cube_max) ? body_max : cube_max;
   assign far_min  = (body_min > cube_min) ? body_min : cube_min;

   assign pos_push = cube_max - body_min;
   assign neg_push = body_max - cube_min;

   // clamp body into the cube, then saturate to the contact range
   always_comb begin
      if (body_ctr < cube_min) begin
         clamped = cube_min;
      end else if (body_ctr > cube_max) begin
         clamped = cube_max;
      end else begin
         clamped = body_ctr;
      end
   end

   always_comb begin
      result.overlap    = near_max - far_min;
      result.hit        = (near_max > far_min);
      result.neg        = !(pos_push < neg_push);
      result.correction = (pos_push < neg_push) ? pos_push : neg_push;
      if (clamped > aabbc_pkg::CONTACT_MAX) begin
         result.contact = aabbc_pkg::CONTACT_MAX[aabbc_pkg::POS_W-1:0];
      end else if (clamped < aabbc_pkg::CONTACT_MIN) begin
         result.contact = aabbc_pkg::CONTACT_MIN[aabbc_pkg::POS_W-1:0];
      end else begin
         result.contact = clamped[aabbc_pkg::POS_W-1:0];
      end
   end

endmodule

[design/aabbc_select.sv]
module aabbc_select (
   input  aabbc_pkg::axis_result_type res_x,
   input  aabbc_pkg::axis_result_type res_y,
   input  aabbc_pkg::axis_result_type res_z,
   output logic                       hit,
   output aabbc_pkg::contact_type     contact
);

   aabbc_pkg::calc_type min_xy;
   aabbc_pkg::calc_type min_ov;

   assign hit = res_x.hit && res_y.hit && res_z.hit;

   assign min_xy = (res_x.overlap < res_y.overlap) ? res_x.overlap : res_y.overlap;
   assign min_ov = (res_z.overlap < min_xy) ? res_z.overlap : min_xy;

   always_comb begin
      // smallest correction wins; ties go to z, then x, then y
      if (res_z.correction <= res_x.correction &&
          res_z.correction <= res_y.correction) begin
         contact.axis = aabbc_pkg::AXIS_Z;
         contact.neg  = res_z.neg;
      end else if (res_x.correction <= res_z.correction &&
                   res_x.correction <= res_y.correction) begin
         contact.axis = aabbc_pkg::AXIS_X;
         contact.neg  = res_x.neg;
      end else begin
         contact.axis = aabbc_pkg::AXIS_Y;
         contact.neg  = res_y.neg;
      end
      contact.contact_x = res_x.contact;
      contact.contact_y = res_y.contact;
      contact.contact_z = res_z.contact;
      if (min_ov > aabbc_pkg::DEPTH_MAX) begin
         contact.depth = aabbc_pkg::DEPTH_MAX[aabbc_pkg::DEPTH_W-1:0];
      end else begin
         contact.depth = min_ov[aabbc_pkg::DEPTH_W-1:0];
      end
   end

endmodule

[design/aabb_unit_block_contact_unit.sv]
// An item taken into the input register strobes its result, if any, out of the result register.
// Throughput: one item per cycle; busy is low whenever reset is low.
// The contact math for an item sits between the input register and the result register.
// Reset (synchronous, active high) drops in-flight items and reloads half_span and
// body_height to their defaults; results are strobed for one cycle and cannot be held off.
`include "aabb_unit_block_contact_unit_defines.svh"

module aabb_unit_block_contact_unit #(
   parameter int FRAC_BITS = aabbc_pkg::DEF_FRAC_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,

   // item input
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [aabbc_pkg::CUBE_W-1:0]    req_cube_x,
   input  logic signed [aabbc_pkg::CUBE_W-1:0]    req_cube_y,
   input  logic signed [aabbc_pkg::CUBE_W-1:0]    req_cube_z,
   input  logic signed [aabbc_pkg::POS_W-1:0]     req_body_x,
   input  logic signed [aabbc_pkg::POS_W-1:0]     req_body_y,
   input  logic signed [aabbc_pkg::POS_W-1:0]     req_body_z,

   // result output
   output logic                                   rsp_strobe,
   output logic [1:0]                             rsp_push_axis,
   output logic                                   rsp_push_negative,
   output logic signed [aabbc_pkg::POS_W-1:0]     rsp_contact_x,
   output logic signed [aabbc_pkg::POS_W-1:0]     rsp_contact_y,
   output logic signed [aabbc_pkg::POS_W-1:0]     rsp_contact_z,
   output logic [aabbc_pkg::DEPTH_W-1:0]          rsp_depth,

   // configuration writes
   input  logic                                   csr_wr_en,
   input  logic [aabbc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [aabbc_pkg::EXT_W-1:0]            csr_wdata
);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [aabbc_pkg::EXT_W-1:0] half_span_ff,   half_span_in;
   logic [aabbc_pkg::EXT_W-1:0] body_height_ff, body_height_in;

   always_comb begin
      half_span_in   = half_span_ff;
      body_height_in = body_height_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            aabbc_pkg::CSR_HALF_SPAN:   half_span_in   = csr_wdata;
            aabbc_pkg::CSR_BODY_HEIGHT: body_height_in = csr_wdata;
            default: ;  // unused index: drop the write
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_span_ff   <= aabbc_pkg::HALF_SPAN_RESET;
         body_height_ff <= aabbc_pkg::BODY_HEIGHT_RESET;
      end else begin
         half_span_ff   <= half_span_in;
         body_height_ff <= body_height_in;
      end
   end

   // ------------------------------------------------------------------
   // Input register: capture every accepted item, no back pressure
   // ------------------------------------------------------------------
   logic accept;
   logic in_valid_ff, in_valid_in;
   logic signed [aabbc_pkg::CUBE_W-1:0] cube_x_ff, cube_y_ff, cube_z_ff;
   logic signed [aabbc_pkg::POS_W-1:0]  body_x_ff, body_y_ff, body_z_ff;

   // The pipeline never stalls; only reset keeps items out.
   assign busy        = reset;
   assign accept      = start && !busy;
   assign in_valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload needs no reset; hold it when nothing arrives
   always_ff @(posedge clock) begin
      if (accept) begin
         cube_x_ff <= req_cube_x;
         cube_y_ff <= req_cube_y;
         cube_z_ff <= req_cube_z;
         body_x_ff <= req_body_x;
         body_y_ff <= req_body_y;
         body_z_ff <= req_body_z;
      end
   end

   // ------------------------------------------------------------------
   // Per-axis overlap, push-out correction and clamped contact
   // x and z extend by half_span each way; y hangs body_height below the top.
   // ------------------------------------------------------------------
   aabbc_pkg::axis_result_type res_x, res_y, res_z;

   aabbc_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
      .cube_pos  (cube_x_ff),
      .body_pos  (body_x_ff),
      .ext_below (half_span_ff),
      .ext_above (half_span_ff),
      .result    (res_x)
   );

   aabbc_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
      .cube_pos  (cube_y_ff),
      .body_pos  (body_y_ff),
      .ext_below (body_height_ff),
      .ext_above ('0),
      .result    (res_y)
   );

   aabbc_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_z (
      .cube_pos  (cube_z_ff),
      .body_pos  (body_z_ff),
      .ext_below (half_span_ff),
      .ext_above (half_span_ff),
      .result    (res_z)
   );

   // ------------------------------------------------------------------
   // Pick the push axis and the depth
   // ------------------------------------------------------------------
   logic                   hit;
   aabbc_pkg::contact_type contact;

   aabbc_select u_select (
      .res_x   (res_x),
      .res_y   (res_y),
      .res_z   (res_z),
      .hit     (hit),
      .contact (contact)
   );

   // ------------------------------------------------------------------
   // Result register: strobe for one cycle only when all three axes overlap
   // ------------------------------------------------------------------
   logic                   out_valid_ff, out_valid_in;
   aabbc_pkg::contact_type result_ff;

   assign out_valid_in = in_valid_ff && hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_valid_in) begin
         result_ff <= contact;
      end
   end

   assign rsp_strobe        = out_valid_ff;
   assign rsp_push_axis     = result_ff.axis;
   assign rsp_push_negative = result_ff.neg;
   assign rsp_contact_x     = result_ff.contact_x;
   assign rsp_contact_y     = result_ff.contact_y;
   assign rsp_contact_z     = result_ff.contact_z;
   assign rsp_depth         = result_ff.depth;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `AABBC_ASSERT_NEXT(a_accept_loads, clock, reset, accept, in_valid_ff)
   `AABBC_ASSERT_NEXT(a_no_item_no_result, clock, reset, !in_valid_ff, !rsp_strobe)
   `AABBC_ASSERT_IMPLY(a_depth_positive, clock, reset, rsp_strobe, rsp_depth != '0)

endmodule
